### hdl/tccw_pkg.sv
package tccw_pkg;

    // Command codes carried in the request.
    localparam logic [1:0] CMD_PUT        = 2'd0;
    localparam logic [1:0] CMD_CLEAR      = 2'd1;
    localparam logic [1:0] CMD_CLEAR_HOME = 2'd2;
    localparam logic [1:0] CMD_READ       = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes.
    localparam int         CFG_IDX_W     = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE = 4'd1;

    localparam int         COLUMNS_RESET = 80;
    localparam logic [7:0] ATTR_RESET    = 8'h0F;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } tccw_req_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_linear;
        logic        did_scroll;
        logic [15:0] cell_data;
    } tccw_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic walk_step;
        logic init_walk;
        logic load_out;
    } tccw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_walk;
        logic walk_last;
    } tccw_stat_t;

endpackage

### hdl/text_console_cell_writer.sv
// Text console engine with a screen store of 16-bit cells and a cursor.
// Requests arrive on req (req_valid / req_stall) and carry a command, a
// character and a cell index. Every request yields exactly one response on
// rsp (rsp_valid / rsp_stall) with the cursor after the command, its linear
// position, a scroll flag and, for a read, the cell contents.
// Configuration (columns, text attribute) is written on the cfg channel,
// which is always ready; write it only while no transaction is in flight.
// Put character, newline without scroll and read pass from accept through
// the finish state into the response register. Clear and scroll walk the
// first ROWS*columns cells one cell per cycle over the single write port
// before the finish state. Requests are taken one at a time.
// After reset all ROWS*MAX_COLUMNS cells (2000 by default) are swept to
// zero, one cell per cycle; req_stall is high meanwhile.
// A response waits in the output register while rsp_stall is high, and the
// next request is accepted during that wait but is not answered until the
// register is free.
module text_console_cell_writer #(
    parameter int ROWS        = 25,
    parameter int MAX_COLUMNS = 80
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  tccw_pkg::tccw_req_t               req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output tccw_pkg::tccw_rsp_t               rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);
    import tccw_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] COLS_RESET =
        CW'((COLUMNS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLUMNS_RESET);

    // The column count is kept already saturated to the range 1 to MAX_COLUMNS.
    logic [CW-1:0] cols_reg, cols_next;
    logic [7:0]    attr_reg, attr_next;
    logic [6:0]    cols_raw;

    tccw_cmd_t  ctl;
    tccw_stat_t stat;

    assign cfg_ready = 1'b1;
    assign cols_raw  = cfg_data[6:0];

    always_comb
    begin
        cols_next = cols_reg;
        attr_next = attr_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:
                begin
                    if (cols_raw == 7'd0)
                        cols_next = CW'(1);
                    else if (32'(cols_raw) > MAX_COLUMNS)
                        cols_next = CW'(MAX_COLUMNS);
                    else
                        cols_next = CW'(cols_raw);
                end
                CFG_ATTRIBUTE:
                begin
                    attr_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            cols_reg <= cols_next;
            attr_reg <= attr_next;
        end
    end

    tccw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    tccw_datapath #(
        .ROWS        (ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat),
        .req   (req),
        .cols  (cols_reg),
        .attr  (attr_reg),
        .rsp   (rsp)
    );

    // Requests are processed one at a time, so the channel closes right after
    // a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while a transaction was in flight");

    // A scroll always leaves the cursor at the start of the bottom row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.did_scroll) |->
            (rsp.cursor_col == 7'd0) && (rsp.cursor_row == 5'(ROWS - 1)))
        else $error("scroll response with cursor off the bottom row start");

    // The controller never steps a walk and accepts a request in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.accept && ctl.walk_step))
        else $error("walk step overlaps a request accept");

    // Only read commands return cell data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_out && !u_datapath.rd_hit_reg) |=> (rsp.cell_data == 16'h0000))
        else $error("cell data returned for a command other than read");

endmodule

### hdl/tccw_ctrl.sv
module tccw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  tccw_pkg::tccw_stat_t  stat,
    output tccw_pkg::tccw_cmd_t   ctl
);
    import tccw_pkg::*;

    localparam logic [1:0] ST_INIT   = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       accept;
    logic       out_free;

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        ctl.accept    = accept;
        ctl.walk_step = (state_reg == ST_WALK) || (state_reg == ST_INIT);
        ctl.init_walk = (state_reg == ST_INIT);
        ctl.load_out  = (state_reg == ST_FINISH) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.walk_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = stat.start_walk ? ST_WALK : ST_FINISH;
            end
            ST_WALK:
            begin
                if (stat.walk_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load_out)
            rsp_valid_next = 1'b1;
        else
            rsp_valid_next = rsp_valid_reg && rsp_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### hdl/tccw_datapath.sv
module tccw_datapath #(
    parameter int ROWS        = 25,
    parameter int MAX_COLUMNS = 80
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tccw_pkg::tccw_cmd_t                 ctl,
    output tccw_pkg::tccw_stat_t                stat,
    input  tccw_pkg::tccw_req_t                 req,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]    cols,
    input  logic [7:0]                          attr,
    output tccw_pkg::tccw_rsp_t                 rsp
);
    import tccw_pkg::*;

    localparam int DEPTH = ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [15:0]   mem [DEPTH];
    logic [15:0]   rd_q_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          scroll_reg, scroll_next;
    logic          rd_hit_reg, rd_hit_next;
    tccw_rsp_t     rsp_reg, rsp_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [15:0]   wr_data;

    logic          is_nl, at_last_row, need_scroll, is_clear, rd_in_range, col_wrap;
    logic [CW-1:0] col_inc;
    logic [LW-1:0] cols_w, wp_l, cur_lin, copy_end, region_last;

    assign cols_w      = LW'(cols);
    assign wp_l        = LW'(wp_reg);
    assign cur_lin     = LW'(row_reg) * cols_w + LW'(col_reg);
    assign copy_end    = LW'((ROWS - 1) * cols);
    assign region_last = LW'(ROWS * cols - 1);

    assign is_nl       = (req.cmd == CMD_PUT) && (req.char_code == NEWLINE_CODE);
    assign at_last_row = (row_reg == LAST_ROW);
    assign need_scroll = is_nl && at_last_row;
    assign is_clear    = (req.cmd == CMD_CLEAR) || (req.cmd == CMD_CLEAR_HOME);
    assign rd_in_range = 32'(req.cell_index) < DEPTH;
    assign col_inc     = col_reg + CW'(1);
    assign col_wrap    = (col_inc >= cols);

    always_comb
    begin
        stat.start_walk = need_scroll || is_clear;
        if (ctl.init_walk)
            stat.walk_last = (wp_reg == LAST_ADDR);
        else
            stat.walk_last = (wp_l == region_last);
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        wp_next     = wp_reg;
        scroll_next = scroll_reg;
        rd_hit_next = rd_hit_reg;
        wr_en       = 1'b0;
        wr_addr     = wp_reg;
        wr_data     = 16'h0000;
        rd_en       = 1'b0;
        rd_addr     = wp_reg;

        if (ctl.accept)
        begin
            scroll_next = need_scroll;
            rd_hit_next = (req.cmd == CMD_READ) && rd_in_range;
            wp_next     = '0;
            unique case (req.cmd)
                CMD_PUT:
                begin
                    if (is_nl)
                    begin
                        col_next = '0;
                        if (at_last_row)
                        begin
                            // Prime the copy: the first source cell is row one, column zero.
                            rd_en   = 1'b1;
                            rd_addr = AW'(cols_w);
                        end
                        else
                        begin
                            row_next = row_reg + RW'(1);
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = cur_lin[AW-1:0];
                        wr_data = {attr, req.char_code};
                        if (col_wrap)
                        begin
                            col_next = '0;
                            row_next = at_last_row ? '0 : row_reg + RW'(1);
                        end
                        else
                        begin
                            col_next = col_inc;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                end
                CMD_CLEAR_HOME:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                CMD_READ:
                begin
                    rd_en   = rd_in_range;
                    rd_addr = AW'(req.cell_index);
                end
                default:
                begin
                end
            endcase
        end
        else if (ctl.walk_step)
        begin
            wr_en   = 1'b1;
            wr_addr = wp_reg;
            if (!ctl.init_walk && scroll_reg)
            begin
                // Cells below the top row move up one row; the bottom row is blanked
                // and its first cell takes the attribute.
                if (wp_l < copy_end)
                    wr_data = rd_q_reg;
                else if (wp_l == copy_end)
                    wr_data = {attr, 8'h00};
                else
                    wr_data = 16'h0000;
                rd_en   = (wp_l + LW'(1)) < copy_end;
                rd_addr = AW'(wp_l + LW'(1) + cols_w);
            end
            wp_next = stat.walk_last ? '0 : wp_reg + AW'(1);
        end
    end

    always_comb
    begin
        rsp_next.cursor_col    = 7'(col_reg);
        rsp_next.cursor_row    = 5'(row_reg);
        rsp_next.cursor_linear = 11'(cur_lin);
        rsp_next.did_scroll    = scroll_reg;
        rsp_next.cell_data     = rd_hit_reg ? rd_q_reg : 16'h0000;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            wp_reg     <= '0;
            scroll_reg <= 1'b0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            wp_reg     <= wp_next;
            scroll_reg <= scroll_next;
            rd_hit_reg <= rd_hit_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

### tb/text_console_cell_writer_tb.sv
`timescale 1ns / 1ps

module text_console_cell_writer_tb;
    import tccw_pkg::*;

    localparam int ROWS        = 25;
    localparam int MAX_COLUMNS = 80;
    localparam int STORE_DEPTH = ROWS * MAX_COLUMNS;

    // The limit leaves a wide margin above the slowest legal run, which is
    // made up of the reset sweep, full-width clears and scrolls, and the random
    // idle gaps on both sides of every transaction.
    localparam int CYCLE_LIMIT = 4_000_000;

    localparam int PHASE_COUNT = 16;
    localparam int PHASE_ITEMS = 95;

    // Console scoreboard. It keeps its own copy of the screen, the cursor and
    // the two registers, works out the response for every request accepted by
    // the block, and compares responses against those in arrival order.
    class console_scoreboard;
        logic [15:0]  screen [STORE_DEPTH];
        int unsigned  cur_col;
        int unsigned  cur_row;
        logic [6:0]   columns_reg;
        logic [7:0]   attr_reg;
        tccw_rsp_t    expected_q [$];
        int unsigned  mismatches;

        function new();
            foreach (screen[i])
            begin
                screen[i] = '0;
            end
            cur_col     = 0;
            cur_row     = 0;
            columns_reg = 7'(COLUMNS_RESET);
            attr_reg    = ATTR_RESET;
            mismatches  = 0;
        endfunction

        // A width of zero behaves as one column; anything above the store
        // width saturates to the store width.
        function int unsigned active_columns();
            if (columns_reg == 0)
                return 1;
            if (columns_reg > MAX_COLUMNS)
                return MAX_COLUMNS;
            return columns_reg;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [7:0] data);
            if (index == CFG_COLUMNS)
                columns_reg = data[6:0];
            else if (index == CFG_ATTRIBUTE)
                attr_reg = data;
        endfunction

        // Clear and scroll only touch the first ROWS rows at the current width.
        function void blank_screen(int unsigned cols);
            for (int unsigned i = 0; i < ROWS * cols && i < STORE_DEPTH; i++)
            begin
                screen[i] = '0;
            end
        endfunction

        function void scroll_screen(int unsigned cols);
            for (int unsigned i = 0; i < (ROWS - 1) * cols; i++)
            begin
                screen[i] = screen[i + cols];
            end
            for (int unsigned c = 0; c < cols; c++)
            begin
                screen[(ROWS - 1) * cols + c] = '0;
            end
        endfunction

        function void note_request(tccw_req_t r);
            tccw_rsp_t   e;
            int unsigned cols;
            int unsigned addr;
            cols = active_columns();
            e    = '0;
            case (r.cmd)
                CMD_PUT:
                begin
                    if (r.char_code == NEWLINE_CODE)
                    begin
                        cur_col = 0;
                        cur_row++;
                        if (cur_row >= ROWS)
                        begin
                            scroll_screen(cols);
                            cur_row = ROWS - 1;
                            screen[cur_row * cols] = {attr_reg, 8'h00};
                            e.did_scroll = 1'b1;
                        end
                    end
                    else
                    begin
                        // A cursor left beyond a reduced width still writes at
                        // the linear address and then wraps.
                        addr = cur_row * cols + cur_col;
                        if (addr < STORE_DEPTH)
                            screen[addr] = {attr_reg, r.char_code};
                        cur_col++;
                        if (cur_col >= cols)
                        begin
                            cur_col = 0;
                            cur_row++;
                            if (cur_row >= ROWS)
                                cur_row = 0;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    blank_screen(cols);
                end
                CMD_CLEAR_HOME:
                begin
                    blank_screen(cols);
                    cur_col = 0;
                    cur_row = 0;
                end
                CMD_READ:
                begin
                    if (r.cell_index < STORE_DEPTH)
                        e.cell_data = screen[r.cell_index];
                end
            endcase
            e.cursor_col    = 7'(cur_col);
            e.cursor_row    = 5'(cur_row);
            e.cursor_linear = 11'(cur_row * cols + cur_col);
            expected_q.push_back(e);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(tccw_rsp_t got);
            tccw_rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("response %h arrived with no request outstanding", got);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("cursor_col", e.cursor_col, got.cursor_col);
            compare_field("cursor_row", e.cursor_row, got.cursor_row);
            compare_field("cursor_linear", e.cursor_linear, got.cursor_linear);
            compare_field("did_scroll", e.did_scroll, got.did_scroll);
            compare_field("cell_data", e.cell_data, got.cell_data);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    tccw_req_t            req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    tccw_rsp_t            rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // Per-phase switches: when cleared, that side runs back to back.
    bit                   send_gaps;
    bit                   take_gaps;

    console_scoreboard    board;

    text_console_cell_writer #(
        .ROWS        (ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Response side. Outputs are sampled right after the rising edge, so the
    // values seen are the ones the edge itself acted on. After each response
    // is taken, a random hold is drawn, and the stall stays high until it runs out.
    initial
    begin : response_side
        int hold;
        hold      = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                board.check_response(rsp);
                hold = take_gaps ? $urandom_range(0, 3) : 0;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            rsp_stall <= (hold > 0);
        end
    end

    // The run ends here if the block stops answering.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("text_console_cell_writer test failed");
        $finish;
    end

    function automatic tccw_req_t make_request(logic [1:0] cmd, logic [7:0] ch,
                                               logic [10:0] index);
        tccw_req_t r;
        r.cmd        = cmd;
        r.char_code  = ch;
        r.cell_index = index;
        return r;
    endfunction

    // Mostly printable traffic with frequent newlines so that the cursor walks
    // down to the last row and scrolls. Reads mostly target the visible region
    // at the current width, the rest the whole index range including the part
    // past the end of the store.
    function automatic tccw_req_t random_request();
        tccw_req_t   r;
        int unsigned pick;
        int unsigned span;
        pick         = $urandom_range(0, 99);
        span         = ROWS * board.active_columns();
        r.cmd        = CMD_PUT;
        r.char_code  = 8'($urandom);
        r.cell_index = 11'($urandom);
        if (pick < 62)
        begin
            if (pick < 18)
                r.char_code = NEWLINE_CODE;
        end
        else if (pick < 64)
        begin
            r.cmd = CMD_CLEAR;
        end
        else if (pick < 66)
        begin
            r.cmd = CMD_CLEAR_HOME;
        end
        else
        begin
            r.cmd = CMD_READ;
            if (pick < 86)
                r.cell_index = 11'($urandom_range(0, span - 1));
        end
        return r;
    endfunction

    // Presents one transaction, after an optional idle gap, and returns at the
    // edge that accepts it. Valid stays high on return so that a following
    // transaction with no gap goes out back to back.
    task automatic send(tccw_req_t r);
        int gap;
        gap = send_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        board.note_request(r);
    endtask

    // Stops sending and waits for every outstanding response. The short
    // pause afterwards lets the block settle before a register write.
    task automatic drain();
        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Valid is left high so that several writes can go out in a row; the
    // caller lowers it once the batch is done.
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [7:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        board.write_register(index, data);
    endtask

    // After a drain, sets the width and the attribute, plus one write to an unused
    // index, which the block must ignore.
    task automatic configure(logic [7:0] cols, logic [7:0] attr);
        drain();
        write_register(CFG_COLUMNS, cols);
        write_register(CFG_ATTRIBUTE, attr);
        write_register(CFG_IDX_W'($urandom_range(CFG_ATTRIBUTE + 1, 2 ** CFG_IDX_W - 1)),
                       8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        // Width per phase. Some values carry bits above the register width
        // or exceed the store width, so they land on the zero and saturation
        // cases. Most phases use narrow screens to keep clears and scrolls short.
        logic [7:0] phase_cols [PHASE_COUNT];
        logic [7:0] attr;

        phase_cols = '{
            8'h01, 8'h00, 8'h04, 8'h50, 8'h02, 8'hFF, 8'h07, 8'h03,
            8'h0C, 8'hD1, 8'h05, 8'h80, 8'h09, 8'h06, 8'h10, 8'h02
        };
        board      = new();
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        send_gaps  = 1'b1;
        take_gaps  = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at reset settings first. The block holds off requests
        // while it sweeps the store after reset; send simply waits that out.
        send(make_request(CMD_PUT, 8'h41, 11'd0));
        send(make_request(CMD_PUT, 8'hFF, 11'd0));
        send(make_request(CMD_PUT, 8'h00, 11'h7FF));
        send(make_request(CMD_PUT, 8'h80, 11'd0));
        send(make_request(CMD_PUT, 8'h7F, 11'd0));
        send(make_request(CMD_PUT, NEWLINE_CODE, 11'd0));
        for (int i = 0; i < 6; i++)
        begin
            send(make_request(CMD_PUT, 8'h31 + 8'(i), 11'd0));
        end
        send(make_request(CMD_READ, 8'h00, 11'd0));
        send(make_request(CMD_READ, 8'hFF, 11'd1));
        send(make_request(CMD_READ, 8'h00, 11'd4));
        send(make_request(CMD_READ, 8'h00, 11'd80));
        send(make_request(CMD_READ, 8'h00, 11'd85));
        send(make_request(CMD_READ, 8'h00, 11'd1999));
        // Reads past the end of the store return zero.
        send(make_request(CMD_READ, 8'h00, 11'd2000));
        send(make_request(CMD_READ, 8'h00, 11'h7FF));

        // Narrow the screen while the cursor sits beyond the new width: the
        // put lands at the linear address and the cursor wraps to the next row.
        configure(8'h04, 8'hF0);
        send(make_request(CMD_PUT, 8'h43, 11'd0));
        send(make_request(CMD_READ, 8'h00, 11'd10));

        // A zero width acts as one column. The clear only covers the first
        // ROWS cells, so the cell at index 80 keeps its character.
        configure(8'h00, 8'hAA);
        send(make_request(CMD_CLEAR, 8'h00, 11'd0));
        send(make_request(CMD_READ, 8'h00, 11'd80));
        send(make_request(CMD_READ, 8'h00, 11'd4));
        send(make_request(CMD_CLEAR_HOME, 8'h00, 11'd0));

        // Oversized width saturates to the store width.
        configure(8'hFF, 8'h00);
        send(make_request(CMD_PUT, 8'h5A, 11'd0));
        send(make_request(CMD_READ, 8'h00, 11'd0));

        // Random phases. Each one changes the width and the attribute while
        // idle, then runs a stream of random commands. Some phases run one or
        // both sides without gaps, and every other phase drains halfway through.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
                attr = 8'h00;
            else if (p == 1)
                attr = 8'hFF;
            else
                attr = 8'($urandom);
            configure(phase_cols[p], attr);
            send_gaps = (p % 3 != 1);
            take_gaps = (p % 4 != 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p % 2 == 1 && i == PHASE_ITEMS / 2)
                    drain();
                send(random_request());
            end
        end

        // Wait for the last responses; the watchdog covers a block that hangs.
        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0)
            $display("text_console_cell_writer test passed");
        else
            $display("text_console_cell_writer test failed");
        $finish;
    end

endmodule

### text_console_cell_writer.f
hdl/tccw_pkg.sv
hdl/tccw_ctrl.sv
hdl/tccw_datapath.sv
hdl/text_console_cell_writer.sv
tb/text_console_cell_writer_tb.sv
